### rtl/ced_pkg.sv
// Shared types and constants of the curvature extrema detector.
package ced_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int CNT_W      = $clog2(MAX_POINTS);
	localparam int CURV_W     = 48;
	localparam int FLOOR_W    = 47;
	localparam int ARC_W      = 17;
	localparam int IDX_W      = 12;
	localparam int WIN_CELLS  = 4;
	// Headroom for 23*c, 10*limit and 4*|c| in the threshold compares.
	localparam int EXT_W      = CURV_W + 6;

	localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_POINTS - 1);
	localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(WIN_CELLS);
	localparam logic [CNT_W-1:0] CENTER_LAG  = CNT_W'(2);
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(6711);

	typedef enum logic [1:0] {
		REG_CURVE_MAX  = 2'd0,
		REG_CURVE_MIN  = 2'd1,
		REG_SCALE_MODE = 2'd2,
		REG_MAG_FLOOR  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CURV_W-1:0] curve_max;
		logic signed [CURV_W-1:0] curve_min;
		logic                     max_scale_mode;
		logic [FLOOR_W-1:0]       magnitude_floor;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         index;
		logic [ARC_W-1:0]         arc;
		logic signed [CURV_W-1:0] curv;
	} result_t;

	// Two's complement magnitude; the most negative code maps to 2^47 unsigned.
	function automatic logic [CURV_W-1:0] magnitude(input logic signed [CURV_W-1:0] v);
		magnitude = v[CURV_W-1] ? (~v + CURV_W'(1)) : v;
	endfunction

endpackage

### rtl/curvature_extrema_detector_core.sv
// Top level of the curvature extrema detector: window cells, peak test, result queue.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | in_valid/in_stall  | curv_sample, arc_pos, last_sample
//   output   | out_valid/out_stall| peak_index, peak_arc_pos, peak_curv
//   config   | cfg_wr_en          | cfg_index, cfg_data
//
// One sample is taken per cycle while in_stall is low; a peak is pushed into the
// result queue by the transaction that completes its right neighbour and leaves from the queue head.
// in_stall rises only while both result queue entries hold undelivered peaks.
// Reset clears the window cells, arc taps, sample count, queue and config
// registers (magnitude floor back to its default).
module curvature_extrema_detector_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [ced_pkg::CURV_W-1:0]  curv_sample,
	input  logic [ced_pkg::ARC_W-1:0]          arc_pos,
	input  logic                               last_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ced_pkg::IDX_W-1:0]          peak_index,
	output logic [ced_pkg::ARC_W-1:0]          peak_arc_pos,
	output logic signed [ced_pkg::CURV_W-1:0]  peak_curv,
	input  logic                               cfg_wr_en,
	input  logic [1:0]                         cfg_index,
	input  logic [ced_pkg::CURV_W-1:0]         cfg_data
);

	ced_pkg::cfg_t                    cfg_q;
	logic [ced_pkg::CNT_W-1:0]        count_q;
	logic [ced_pkg::ARC_W-1:0]        arc_q [2];
	logic signed [ced_pkg::CURV_W-1:0] cell_curv [ced_pkg::WIN_CELLS];
	logic [ced_pkg::CURV_W-1:0]       cell_mag [ced_pkg::WIN_CELLS];
	logic [ced_pkg::CURV_W-1:0]       mag_x;
	logic                             accept, shift_en, clear, hit, full;
	ced_pkg::result_t                 res, head;

	assign accept   = in_valid && !in_stall;
	assign shift_en = accept && !last_sample;
	assign clear    = accept && last_sample;
	assign in_stall = full;
	assign mag_x    = ced_pkg::magnitude(curv_sample);

	// Config registers: the user must write them only while the block is idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve_max       <= '0;
			cfg_q.curve_min       <= '0;
			cfg_q.max_scale_mode  <= 1'b0;
			cfg_q.magnitude_floor <= ced_pkg::FLOOR_RESET;
		end else if (cfg_wr_en) begin
			unique case (ced_pkg::cfg_reg_t'(cfg_index))
				ced_pkg::REG_CURVE_MAX:  cfg_q.curve_max       <= $signed(cfg_data);
				ced_pkg::REG_CURVE_MIN:  cfg_q.curve_min       <= $signed(cfg_data);
				ced_pkg::REG_SCALE_MODE: cfg_q.max_scale_mode  <= cfg_data[0];
				ced_pkg::REG_MAG_FLOOR:  cfg_q.magnitude_floor <= cfg_data[ced_pkg::FLOOR_W-1:0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	// Sample count within the curve: advance and saturate, drop to zero at curve end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			arc_q[0] <= '0;
			arc_q[1] <= '0;
		end else if (clear) begin
			count_q <= '0;
			arc_q[0] <= '0;
			arc_q[1] <= '0;
		end else if (shift_en) begin
			if (count_q != ced_pkg::CNT_MAX) begin
				count_q <= count_q + ced_pkg::CNT_W'(1);
			end
			arc_q[0] <= arc_pos;
			arc_q[1] <= arc_q[0];
		end
	end

	// Chain of window cells, newest first; each hands its sample to the next.
	for (genvar i = 0; i < ced_pkg::WIN_CELLS; i++) begin : g_cell
		ced_tap_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.clear    (clear),
			.curv_in  ((i == 0) ? curv_sample : cell_curv[(i == 0) ? 0 : i-1]),
			.mag_in   ((i == 0) ? mag_x : cell_mag[(i == 0) ? 0 : i-1]),
			.curv_q   (cell_curv[i]),
			.mag_q    (cell_mag[i])
		);
	end

	// Centre is the second cell; neighbours are the incoming sample and the other cells.
	ced_peak_eval u_eval (
		.win_full (count_q >= ced_pkg::CNT_FULL),
		.cfg      (cfg_q),
		.center   (cell_curv[1]),
		.mag_c    (cell_mag[1]),
		.mag_n0   (mag_x),
		.mag_n1   (cell_mag[0]),
		.mag_n2   (cell_mag[2]),
		.mag_n3   (cell_mag[3]),
		.hit      (hit)
	);

	always_comb begin
		res.index = ced_pkg::IDX_W'(count_q - ced_pkg::CENTER_LAG);
		res.arc   = arc_q[1];
		res.curv  = cell_curv[1];
	end

	ced_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && hit),
		.push_data  (res),
		.pop_stall  (out_stall),
		.head_valid (out_valid),
		.head       (head),
		.full       (full)
	);

	assign peak_index   = head.index;
	assign peak_arc_pos = head.arc;
	assign peak_curv    = head.curv;

endmodule

### rtl/ced_tap_cell.sv
// One window cell: holds a curvature sample and its magnitude, passes it on.
module ced_tap_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               shift_en,
	input  logic                               clear,
	input  logic signed [ced_pkg::CURV_W-1:0]  curv_in,
	input  logic [ced_pkg::CURV_W-1:0]         mag_in,
	output logic signed [ced_pkg::CURV_W-1:0]  curv_q,
	output logic [ced_pkg::CURV_W-1:0]         mag_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curv_q <= '0;
			mag_q  <= '0;
		end else if (clear) begin
			curv_q <= '0;
			mag_q  <= '0;
		end else if (shift_en) begin
			curv_q <= curv_in;
			mag_q  <= mag_in;
		end
	end

endmodule

### rtl/ced_peak_eval.sv
// Peak test on the window centre: local maximum of magnitude plus, in max-scale mode, scale thresholds and floor.
module ced_peak_eval (
	input  logic                               win_full,
	input  ced_pkg::cfg_t                      cfg,
	input  logic signed [ced_pkg::CURV_W-1:0]  center,
	input  logic [ced_pkg::CURV_W-1:0]         mag_c,
	input  logic [ced_pkg::CURV_W-1:0]         mag_n0,
	input  logic [ced_pkg::CURV_W-1:0]         mag_n1,
	input  logic [ced_pkg::CURV_W-1:0]         mag_n2,
	input  logic [ced_pkg::CURV_W-1:0]         mag_n3,
	output logic                               hit
);

	logic signed [ced_pkg::EXT_W-1:0] c_x, c23, max10, min10, max_x, c4_mag, min_mag;
	logic local_peak, pos_ok, neg_ok, floor_ok, scale_ok;

	always_comb begin
		c_x     = ced_pkg::EXT_W'(center);
		c23     = c_x * ced_pkg::EXT_W'(23);
		max10   = ced_pkg::EXT_W'(cfg.curve_max) * ced_pkg::EXT_W'(10);
		min10   = ced_pkg::EXT_W'(cfg.curve_min) * ced_pkg::EXT_W'(10);
		max_x   = ced_pkg::EXT_W'(cfg.curve_max);
		c4_mag  = $signed({6'b0, mag_c}) <<< 2;
		min_mag = $signed({6'b0, ced_pkg::magnitude(cfg.curve_min)});

		local_peak = (mag_c > mag_n0) && (mag_c > mag_n1) &&
		             (mag_c > mag_n2) && (mag_c > mag_n3);

		pos_ok   = !center[ced_pkg::CURV_W-1] && (center != '0) &&
		           (c23 > max10) && (c4_mag > min_mag);
		neg_ok   = center[ced_pkg::CURV_W-1] && (c23 < min10) && (c4_mag > max_x);
		floor_ok = mag_c > {1'b0, cfg.magnitude_floor};
		scale_ok = (pos_ok || neg_ok) && floor_ok;

		hit = win_full && local_peak && (!cfg.max_scale_mode || scale_ok);
	end

endmodule

### rtl/ced_result_queue.sv
// Two-entry result queue that decouples peak detection from the output stall.
module ced_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ced_pkg::result_t  push_data,
	input  logic              pop_stall,
	output logic              head_valid,
	output ced_pkg::result_t  head,
	output logic              full
);

	logic [1:0]       cnt_q;
	ced_pkg::result_t slot0_q, slot1_q;
	logic             pop;

	assign head_valid = (cnt_q != 2'd0);
	assign full       = (cnt_q == 2'd2);
	assign head       = slot0_q;
	assign pop        = head_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot0_q <= (push && cnt_q == 2'd1) ? push_data : slot1_q;
			if (push && cnt_q == 2'd2) begin
				slot1_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= push_data;
			end else begin
				slot1_q <= push_data;
			end
		end
	end

endmodule

### tb/curvature_extrema_detector_core_tb.sv
// Self-checking testbench for the curvature extrema detector core.
`timescale 1ns / 100ps

module curvature_extrema_detector_core_tb;

	import ced_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 240;
	localparam logic signed [CURV_W-1:0] CURV_TOP = 48'sh7FFF_FFFF_FFFF;

	typedef struct {
		logic signed [CURV_W-1:0] curv;
		logic [ARC_W-1:0]         arc;
		logic                     last;
	} sample_t;

	// DUT ports; every input starts at a known value
	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic signed [CURV_W-1:0] curv_sample  = '0;
	logic [ARC_W-1:0]         arc_pos      = '0;
	logic                     last_sample  = 1'b0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic [IDX_W-1:0]         peak_index;
	logic [ARC_W-1:0]         peak_arc_pos;
	logic signed [CURV_W-1:0] peak_curv;
	logic                     cfg_wr_en    = 1'b0;
	logic [1:0]               cfg_index    = '0;
	logic [CURV_W-1:0]        cfg_data     = '0;

	// Stimulus side
	sample_t pending_samples[$];
	sample_t next_sample;
	int      items_queued = 0;
	int      items_taken  = 0;
	int      in_gap       = 0;
	int      out_wait     = 0;
	int      in_idle_pct  = 0;
	int      out_idle_pct = 0;
	int      hold_left    = 0;
	logic    in_taken     = 1'b0;
	logic    out_taken    = 1'b0;

	// Shadow of the detector: thresholds and the five-sample window
	longint                   lim_max   = 0;
	longint                   lim_min   = 0;
	longint                   floor_lim = 6711;
	bit                       scale_on  = 1'b0;
	logic signed [CURV_W-1:0] win_curv [WIN_CELLS] = '{default: '0};
	logic [ARC_W-1:0]         win_arc  [2]         = '{default: '0};
	logic [CNT_W-1:0]         win_count = '0;

	// Checking side
	result_t expected_peaks[$];
	result_t oldest_peak;
	int      mismatches   = 0;
	int      quiet_cycles = 0;

	curvature_extrema_detector_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.curv_sample  (curv_sample),
		.arc_pos      (arc_pos),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.peak_index   (peak_index),
		.peak_arc_pos (peak_arc_pos),
		.peak_curv    (peak_curv),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint curv_mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Random magnitude of at most the given width.
	function automatic longint rand_mag(input int width);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return longint'(r & ((64'd1 << width) - 64'd1));
	endfunction

	// Mix tiny values (ties, zeros) with magnitudes of every width up to the limit.
	function automatic logic signed [CURV_W-1:0] draw_curv(input int bits);
		longint m;
		if ($urandom_range(0, 9) == 0) begin
			m = $urandom_range(0, 3);
		end else begin
			m = rand_mag($urandom_range(1, bits));
		end
		return ($urandom_range(0, 1) != 0) ? CURV_W'(-m) : CURV_W'(m);
	endfunction

	function automatic int draw_wait(input int pct);
		return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 19) : 0;
	endfunction

	// Advance the shadow window by one sample and queue the peak it completes, if any.
	function automatic void track_sample(input logic signed [CURV_W-1:0] x,
	                                     input logic [ARC_W-1:0] arc, input logic last);
		longint  c;
		longint  m;
		bit      hit;
		result_t peak;
		c = win_curv[1];
		m = curv_mag(c);
		if (win_count >= CNT_FULL) begin
			// Strict compare against both neighbours on each side; the new
			// sample stands in as the right-most one, even on the last sample.
			hit = m > curv_mag(win_curv[0]) && m > curv_mag(x) &&
			      m > curv_mag(win_curv[2]) && m > curv_mag(win_curv[3]);
			// A hit implies a nonzero centre, so only the two signs remain.
			if (hit && scale_on) begin
				if (c > 0) begin
					hit = (23 * c > 10 * lim_max) && (4 * c > curv_mag(lim_min));
				end else begin
					hit = (23 * c < 10 * lim_min) && (4 * m > lim_max);
				end
				hit = hit && (m > floor_lim);
			end
			if (hit) begin
				peak.index = win_count - CENTER_LAG;
				peak.arc   = win_arc[1];
				peak.curv  = win_curv[1];
				expected_peaks = {expected_peaks, peak};
			end
		end
		if (last) begin
			win_curv  = '{default: '0};
			win_arc   = '{default: '0};
			win_count = '0;
		end else begin
			win_curv[3] = win_curv[2];
			win_curv[2] = win_curv[1];
			win_curv[1] = win_curv[0];
			win_curv[0] = x;
			win_arc[1]  = win_arc[0];
			win_arc[0]  = arc;
			if (win_count != CNT_MAX) begin
				win_count = win_count + 1'b1;
			end
		end
	endfunction

	task automatic queue_sample(input logic signed [CURV_W-1:0] curv,
	                            input logic [ARC_W-1:0] arc, input logic last);
		sample_t s;
		s.curv = curv;
		s.arc  = arc;
		s.last = last;
		pending_samples = {pending_samples, s};
		items_queued++;
	endtask

	// Queue one whole curve: arc positions mostly ramp from 0 to 1.0, some jump anywhere.
	task automatic queue_curve(input int len, input int bits);
		logic [ARC_W-1:0] arc;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				arc = ARC_W'($urandom_range(0, 131071));
			end else begin
				arc = (len > 1) ? ARC_W'((i * 65536) / (len - 1)) : '0;
			end
			queue_sample(draw_curv(bits), arc, i == len - 1);
		end
	endtask

	// Mostly curves long enough to reach the peak test; some too short to, a few long.
	task automatic queue_random_curves(input int count);
		int target;
		int sel;
		int len;
		target = items_queued + count;
		while (items_queued < target) begin
			sel = $urandom_range(0, 19);
			if (sel < 2) begin
				len = $urandom_range(1, 4);
			end else if (sel < 19) begin
				len = $urandom_range(5, 40);
			end else begin
				len = $urandom_range(41, 200);
			end
			queue_curve(len, ($urandom_range(0, 3) == 0) ? $urandom_range(4, 46) : 47);
		end
	endtask

	// Write one register and mirror it in the shadow; only called while idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [CURV_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_CURVE_MAX:  lim_max   = $signed(data);
			REG_CURVE_MIN:  lim_min   = $signed(data);
			REG_SCALE_MODE: scale_on  = data[0];
			REG_MAG_FLOOR:  floor_lim = longint'(data[FLOOR_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait until every sample is taken and every peak delivered, then let the pipe drain.
	task automatic settle();
		while (items_taken != items_queued || expected_peaks.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		@(posedge clk);
	endtask

	// Input driver: take the transaction at the rising edge, present the next one
	// at the falling edge. Hold the payload while stalled.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			track_sample(curv_sample, arc_pos, last_sample);
			items_taken++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap = in_gap - 1;
			end else if (pending_samples.size() != 0) begin
				next_sample = pending_samples.pop_front();
				curv_sample <= next_sample.curv;
				arc_pos     <= next_sample.arc;
				last_sample <= next_sample.last;
				in_valid    <= 1'b1;
				in_gap = draw_wait(in_idle_pct);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted down here once the stimulus arms it.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver stall: a fresh random wait after every delivered peak.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_wait = draw_wait(out_idle_pct);
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (out_wait != 0) begin
				out_stall <= 1'b1;
				out_wait = out_wait - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: compare each delivered peak with the oldest expectation.
	always @(posedge clk) begin
		out_taken <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_peaks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected peak: index %0d arc %0d curv %0d",
					         peak_index, peak_arc_pos, peak_curv);
				end
			end else begin
				oldest_peak = expected_peaks.pop_front();
				if (peak_index !== oldest_peak.index || peak_arc_pos !== oldest_peak.arc ||
				    peak_curv !== oldest_peak.curv) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"peak mismatch: expected index %0d arc %0d curv %0d,",
						          " got index %0d arc %0d curv %0d"},
						         oldest_peak.index, oldest_peak.arc, oldest_peak.curv,
						         peak_index, peak_arc_pos, peak_curv);
					end
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction in %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed curves under reset settings (every local peak counts).
		// Too short for any centre: four samples, nothing comes out.
		queue_sample(48'sd5, 17'd0, 1'b0);
		queue_sample(-48'sd9, 17'd100, 1'b0);
		queue_sample(48'sd7, 17'd200, 1'b0);
		queue_sample(48'sd2, 17'd300, 1'b1);
		// Largest positive centre with an out-of-range arc; the last sample is its
		// right-most neighbour.
		queue_sample(48'sd1, 17'd0, 1'b0);
		queue_sample(-48'sd2, 17'd100, 1'b0);
		queue_sample(CURV_TOP, 17'd131071, 1'b0);
		queue_sample(48'sd3, 17'd200, 1'b0);
		queue_sample(-48'sd4, 17'd65536, 1'b1);
		// Most negative allowed centre among zeros, arc exactly 1.0.
		queue_sample(48'sd0, 17'd0, 1'b0);
		queue_sample(48'sd0, 17'd0, 1'b0);
		queue_sample(-CURV_TOP, 17'd65536, 1'b0);
		queue_sample(48'sd0, 17'd0, 1'b0);
		queue_sample(48'sd0, 17'd0, 1'b1);
		// Equal magnitudes of opposite sign do not make a peak.
		queue_sample(-48'sd6, 17'd0, 1'b0);
		queue_sample(48'sd6, 17'd10, 1'b0);
		queue_sample(-48'sd6, 17'd20, 1'b0);
		queue_sample(48'sd1, 17'd30, 1'b0);
		queue_sample(48'sd0, 17'd40, 1'b0);
		queue_sample(48'sd5, 17'd50, 1'b1);
		settle();

		// Hold the receiver off while the sender streams at full rate so the
		// result queue fills and the input stalls.
		in_idle_pct  <= 0;
		out_idle_pct <= 0;
		hold_left    <= HOLD_CYCLES;
		queue_random_curves(300);
		settle();

		in_idle_pct  <= 30;
		out_idle_pct <= 30;
		queue_random_curves(250);
		settle();

		// Max-scale mode against moderate limits and a small floor.
		write_reg(REG_CURVE_MAX, CURV_W'(rand_mag(40)));
		write_reg(REG_CURVE_MIN, CURV_W'(-rand_mag(40)));
		write_reg(REG_MAG_FLOOR, CURV_W'(1000));
		write_reg(REG_SCALE_MODE, CURV_W'(1));
		in_idle_pct  <= 50;
		out_idle_pct <= 50;
		@(posedge clk);
		queue_random_curves(350);
		settle();

		// Widest limits, zero floor: only near-full-scale peaks pass.
		write_reg(REG_CURVE_MAX, CURV_TOP);
		write_reg(REG_CURVE_MIN, -CURV_TOP);
		write_reg(REG_MAG_FLOOR, CURV_W'(0));
		in_idle_pct  <= 100;
		out_idle_pct <= 20;
		@(posedge clk);
		queue_random_curves(300);
		settle();

		// Zero limits: the floor alone decides.
		write_reg(REG_CURVE_MAX, CURV_W'(0));
		write_reg(REG_CURVE_MIN, CURV_W'(0));
		write_reg(REG_MAG_FLOOR, CURV_W'(64'd1 << 36));
		in_idle_pct  <= 20;
		out_idle_pct <= 100;
		@(posedge clk);
		queue_random_curves(300);
		settle();

		// Inverted extreme limits and the largest floor: nothing may pass.
		write_reg(REG_CURVE_MAX, -CURV_TOP);
		write_reg(REG_CURVE_MIN, CURV_TOP);
		write_reg(REG_MAG_FLOOR, CURV_W'((64'd1 << FLOOR_W) - 64'd1));
		in_idle_pct  <= 40;
		out_idle_pct <= 40;
		@(posedge clk);
		queue_random_curves(150);
		settle();

		// Back to max-scale with random limits and the default floor.
		write_reg(REG_CURVE_MAX, CURV_W'(rand_mag(46)));
		write_reg(REG_CURVE_MIN, CURV_W'(-rand_mag(46)));
		write_reg(REG_MAG_FLOOR, CURV_W'(FLOOR_RESET));
		write_reg(REG_SCALE_MODE, CURV_W'(1));
		in_idle_pct  <= 60;
		out_idle_pct <= 60;
		@(posedge clk);
		queue_random_curves(200);
		settle();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_peaks.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
